// ===== design/pmdf_pkg.sv =====
// Shared types and constants of the probe request MAC dedup filter.
// No dependencies; imported by every module of the block.
`default_nettype none
package pmdf_pkg;

	localparam int MAC_W   = 48;
	localparam int FC_W    = 16;
	localparam int RSSI_W  = 8;
	localparam int CHAN_W  = 4;
	localparam int COUNT_W = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [FC_W-1:0] FC_TYPE_MASK    = 16'h000C;
	localparam logic [FC_W-1:0] FC_SUBTYPE_MASK = 16'h00F0;
	localparam logic [FC_W-1:0] FC_PROBE_REQ    = 16'h0040;
	localparam int LOCAL_BIT = 41;

	localparam logic [CHAN_W-1:0] FIRST_CHANNEL = 4'd1;
	localparam logic [CHAN_W-1:0] LAST_CHANNEL  = 4'd14;
	localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'hFF;

	localparam logic MODE_FRAME = 1'b0;
	localparam logic MODE_HOP   = 1'b1;
	localparam logic KIND_ADDR  = 1'b0;
	localparam logic KIND_CHAN  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_LOCAL   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_RESET_ON_SWEEP = 1'b1;

	typedef struct packed {
		logic search;
		logic clear;
	} tbl_cmd_t;

	typedef struct packed {
		logic               done;
		logic               hit;
		logic [COUNT_W-1:0] count;
	} tbl_sts_t;

endpackage
`default_nettype wire

// ===== design/probe_request_mac_dedup_filter_top.sv =====
// Top level of the probe request MAC dedup filter: handshake, frame filter,
// channel counter and result register. Depends on pmdf_pkg and pmdf_table.
// A channel hop item goes through S_EMIT to the output register. A frame that fails the probe
// request or local address check is dropped in the accept cycle. A passing frame
// runs a serial search of the table, one entry compared per cycle through the
// single read port of the table memory; in_ready is low meanwhile.
// A result sits in the output register until taken, and a new item is accepted
// while it waits. The table needs no clearing pass after reset.
`default_nettype none
module probe_request_mac_dedup_filter_top
	import pmdf_pkg::*;
#(
	parameter int TABLE_DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_write,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic                     cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic                     mode,
	input  wire logic [FC_W-1:0]          frame_control,
	input  wire logic [MAC_W-1:0]         source_mac,
	input  wire logic signed [RSSI_W-1:0] signal_strength,
	input  wire logic [CHAN_W-1:0]        rx_channel,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic                          kind,
	output logic [MAC_W-1:0]              address,
	output logic signed [RSSI_W-1:0]      report_rssi,
	output logic [CHAN_W-1:0]             report_channel,
	output logic [COUNT_W-1:0]            client_count
);

	typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_EMIT} state_t;

	state_t                    state_q;
	logic                      ignore_local_q;
	logic                      reset_on_sweep_q;
	logic [CHAN_W-1:0]         channel_q;
	logic [MAC_W-1:0]          mac_q;
	logic signed [RSSI_W-1:0]  rssi_q;
	logic [CHAN_W-1:0]         rx_chan_q;
	logic                      res_kind_q;
	logic [CHAN_W-1:0]         res_chan_q;
	logic [COUNT_W-1:0]        res_count_q;
	logic                      out_valid_q;
	logic                      kind_q;
	logic [MAC_W-1:0]          address_q;
	logic signed [RSSI_W-1:0]  rssi_out_q;
	logic [CHAN_W-1:0]         chan_out_q;
	logic [COUNT_W-1:0]        count_out_q;

	logic              accept;
	logic              pass;
	logic              wrap;
	logic [CHAN_W-1:0] next_chan;
	tbl_cmd_t          cmd;
	tbl_sts_t          sts;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign pass      = ((frame_control & FC_TYPE_MASK) == '0)
		&& ((frame_control & FC_SUBTYPE_MASK) == FC_PROBE_REQ)
		&& !(ignore_local_q && source_mac[LOCAL_BIT]);
	assign wrap      = (channel_q >= LAST_CHANNEL);
	assign next_chan = wrap ? FIRST_CHANNEL : channel_q + 1'b1;

	assign cmd.search = accept && (mode == MODE_FRAME) && pass;
	assign cmd.clear  = accept && (mode == MODE_HOP) && wrap && reset_on_sweep_q;

	pmdf_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.mac   (mac_q),
		.sts   (sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ignore_local_q   <= 1'b1;
			reset_on_sweep_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_IGNORE_LOCAL:   ignore_local_q   <= cfg_data;
				CFG_RESET_ON_SWEEP: reset_on_sweep_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mac_q     <= source_mac;
			rssi_q    <= signal_strength;
			rx_chan_q <= rx_channel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			channel_q   <= FIRST_CHANNEL;
			res_kind_q  <= KIND_ADDR;
			res_chan_q  <= '0;
			res_count_q <= '0;
			out_valid_q <= 1'b0;
			kind_q      <= KIND_ADDR;
			address_q   <= '0;
			rssi_out_q  <= '0;
			chan_out_q  <= '0;
			count_out_q <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_EMIT))
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && (mode == MODE_HOP)) begin
						channel_q   <= next_chan;
						res_kind_q  <= KIND_CHAN;
						res_chan_q  <= next_chan;
						res_count_q <= sts.count;
						state_q     <= S_EMIT;
					end else if (cmd.search) begin
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (sts.done) begin
						if (sts.hit) begin
							state_q <= S_IDLE;
						end else begin
							res_kind_q  <= KIND_ADDR;
							res_chan_q  <= rx_chan_q;
							res_count_q <= sts.count;
							state_q     <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						kind_q      <= res_kind_q;
						address_q   <= (res_kind_q == KIND_CHAN) ? '0 : mac_q;
						rssi_out_q  <= (res_kind_q == KIND_CHAN) ? '0 : rssi_q;
						chan_out_q  <= res_chan_q;
						count_out_q <= res_count_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign address        = address_q;
	assign report_rssi    = rssi_out_q;
	assign report_channel = chan_out_q;
	assign client_count   = count_out_q;

endmodule
`default_nettype wire

// ===== design/pmdf_table.sv =====
// Address table: memory, FIFO pointer/count and the serial search/insert sequencer.
// Depends on pmdf_pkg.
`default_nettype none
module pmdf_table
	import pmdf_pkg::*;
#(
	parameter int TABLE_DEPTH = 128
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire tbl_cmd_t         cmd,
	input  wire logic [MAC_W-1:0] mac,
	output tbl_sts_t              sts
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int SW = (CW > COUNT_W) ? CW : COUNT_W;
	localparam logic [IW:0]   DEPTH_X = (IW + 1)'(TABLE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
	localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_DEPTH - 1);

	typedef enum logic {T_IDLE, T_SEARCH} tstate_t;

	function automatic logic [IW-1:0] wrap_slot(input logic [IW-1:0] base,
		input logic [IW-1:0] off);
		logic [IW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= DEPTH_X)
			sum = sum - DEPTH_X;
		return sum[IW-1:0];
	endfunction

	logic [MAC_W-1:0] mem [TABLE_DEPTH];
	logic [MAC_W-1:0] rdata_s1;
	logic             pend_s1;
	tstate_t          state_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    rd_idx_q;
	logic [IW-1:0]    ptr_q;
	logic             done_q;
	logic             hit_q;

	logic          full;
	logic          more;
	logic          hit_now;
	logic          miss_now;
	logic          we;
	logic [IW-1:0] raddr;
	logic [IW-1:0] waddr;
	logic [SW-1:0] cnt_ext;

	assign full     = (count_q == DEPTH_C);
	assign more     = (rd_idx_q < count_q);
	assign hit_now  = pend_s1 && (rdata_s1 == mac);
	assign miss_now = !pend_s1 && !more;
	assign we       = (state_q == T_SEARCH) && miss_now;
	assign raddr    = wrap_slot(ptr_q, rd_idx_q[IW-1:0]);
	assign waddr    = wrap_slot(ptr_q, full ? '0 : count_q[IW-1:0]);
	assign cnt_ext  = SW'(count_q);

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= mac;
		rdata_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= T_IDLE;
			count_q  <= '0;
			rd_idx_q <= '0;
			ptr_q    <= '0;
			pend_s1  <= 1'b0;
			done_q   <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			done_q <= (state_q == T_SEARCH) && (hit_now || miss_now);
			hit_q  <= (state_q == T_SEARCH) && hit_now;
			case (state_q)
				T_IDLE: begin
					if (cmd.clear) begin
						count_q <= '0;
						ptr_q   <= '0;
					end else if (cmd.search) begin
						rd_idx_q <= '0;
						pend_s1  <= 1'b0;
						state_q  <= T_SEARCH;
					end
				end
				T_SEARCH: begin
					if (hit_now) begin
						state_q <= T_IDLE;
					end else if (miss_now) begin
						if (full)
							ptr_q <= (ptr_q == LAST_SLOT) ? '0 : ptr_q + 1'b1;
						else
							count_q <= count_q + 1'b1;
						state_q <= T_IDLE;
					end else begin
						pend_s1 <= more;
						if (more)
							rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign sts.done  = done_q;
	assign sts.hit   = hit_q;
	assign sts.count = (cnt_ext > SW'(COUNT_MAX)) ? COUNT_MAX : cnt_ext[COUNT_W-1:0];

endmodule
`default_nettype wire

// ===== design/pmdf_checker.sv =====
// Port-level checks of the probe request MAC dedup filter, bound to its top level.
// Depends on pmdf_pkg.
`default_nettype none
module pmdf_checker
	import pmdf_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     cfg_write,
	input wire logic [CFG_IDX_W-1:0]     cfg_index,
	input wire logic                     cfg_data,
	input wire logic                     in_valid,
	input wire logic                     in_ready,
	input wire logic                     mode,
	input wire logic [FC_W-1:0]          frame_control,
	input wire logic [MAC_W-1:0]         source_mac,
	input wire logic signed [RSSI_W-1:0] signal_strength,
	input wire logic [CHAN_W-1:0]        rx_channel,
	input wire logic                     out_valid,
	input wire logic                     out_ready,
	input wire logic                     kind,
	input wire logic [MAC_W-1:0]         address,
	input wire logic signed [RSSI_W-1:0] report_rssi,
	input wire logic [CHAN_W-1:0]        report_channel,
	input wire logic [COUNT_W-1:0]       client_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(address) && $stable(kind)
			&& $stable(client_count))
		else $error("result changed while stalled");

	a_chan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_CHAN) |-> (address == '0) && (report_rssi == '0))
		else $error("channel report carries address data");

	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_CHAN) |->
			(report_channel >= FIRST_CHANNEL) && (report_channel <= LAST_CHANNEL))
		else $error("channel out of range");

	a_addr_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_ADDR) |-> (client_count != '0))
		else $error("new address report with empty table");

endmodule

bind probe_request_mac_dedup_filter_top pmdf_checker u_pmdf_checker (.*);
`default_nettype wire
